@@ rtl/dpfe_pkg.sv @@
// ----------------------------------------------------------------------------
// dpfe_pkg: shared types and constants for the demand paging fault engine
// Page table entry layout, state and protection codes, result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpfe_pkg;

    localparam int PAGES       = 256;
    localparam int FRAMES      = 64;
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int PAGE_CNT_W  = $clog2(PAGES + 1);
    localparam int FRAME_CNT_W = $clog2(FRAMES + 1);
    localparam int SEED_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    // free-frame scan looks at SCAN_LANES owner valid bits per cycle
    localparam int SCAN_LANES  = 8;
    localparam int LANE_W      = $clog2(SCAN_LANES);
    localparam int SCAN_GROUPS = FRAMES / SCAN_LANES;
    localparam int GROUP_W     = $clog2(SCAN_GROUPS);

    localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

    typedef enum logic [1:0] {
        PG_NOT_ALLOC = 2'd0,
        PG_IN_RAM    = 2'd1,
        PG_IN_SWAP   = 2'd2
    } page_state_t;

    typedef enum logic [1:0] {
        PERM_NONE  = 2'd0,
        PERM_READ  = 2'd1,
        PERM_WRITE = 2'd2
    } prot_t;

    typedef enum logic [1:0] {
        ST_UPGRADE   = 2'd0,
        ST_ZERO_FILL = 2'd1,
        ST_SWAP_IN   = 2'd2,
        ST_ERROR     = 2'd3
    } status_t;

    typedef struct packed {
        page_state_t         state;
        page_state_t         prior;
        logic                dirty;
        prot_t               prot;
        logic [FRAME_W-1:0]  frame;
    } page_entry_t;

endpackage

@@ rtl/dpfe_urem.sv @@
// ----------------------------------------------------------------------------
// dpfe_urem: iterative unsigned remainder
// Restoring division, one dividend bit per cycle; gives LFSR value mod count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfe_urem
    import dpfe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SEED_W-1:0]      dividend,
    input  logic [FRAME_CNT_W-1:0] divisor,
    output logic                   done,
    output logic [FRAME_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(SEED_W);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SEED_W-1:0]      shift_reg;
    logic [FRAME_CNT_W-1:0] div_reg;
    logic [FRAME_CNT_W-1:0] rem_reg;
    logic [FRAME_CNT_W:0]   trial;
    logic [FRAME_CNT_W-1:0] rem_next;

    always_comb begin
        trial = {rem_reg, shift_reg[SEED_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = FRAME_CNT_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[FRAME_CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                shift_reg <= dividend;
                div_reg   <= divisor;
                rem_reg   <= '0;
            end else if (busy_reg) begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[SEED_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SEED_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[FRAME_W-1:0];

endmodule

@@ rtl/demand_paging_fault_engine_top.sv @@
// ----------------------------------------------------------------------------
// demand_paging_fault_engine_top: page fault handler, random replacement
// One fault at a time; the next transfer can be taken in the cycle after the result is
// registered, and the result stage holds while the output register is full.
// Error goes straight from transfer to result. Write upgrade reads the page entry first.
// Free frame: owner valid bits scanned 8 per cycle until a free frame is found.
// Eviction: the LFSR modulo unit picks the victim frame, then owner and victim reads.
// Reset clears page and frame valid bits at once; no clearing pass needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module demand_paging_fault_engine_top
    import dpfe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_W-1:0]     s_page_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [FRAME_W-1:0]    m_frame_number,
    output logic                  m_evicted_valid,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic                  m_evict_writeback,
    output logic [1:0]            m_new_protection
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_PAGE,
        S_SCAN,
        S_MOD,
        S_RD_OWNER,
        S_RD_VICTIM,
        S_MAP,
        S_OUT
    } fsm_t;

    // configuration and victim LFSR
    logic [PAGE_CNT_W-1:0]  pages_reg;
    logic [FRAME_CNT_W-1:0] frames_reg;
    logic [SEED_W-1:0]      lfsr_reg;
    logic [SEED_W-1:0]      lfsr_step;
    logic                   lfsr_adv;
    logic [PAGE_CNT_W-1:0]  np_eff;
    logic [FRAME_CNT_W-1:0] nf_eff;
    logic                   cfg_bad;
    logic                   page_err;

    // page table memory and valid bits
    page_entry_t            pt_mem [PAGES];
    logic [PAGES-1:0]       page_valid_reg;
    logic                   pt_rd_en;
    logic [PAGE_W-1:0]      pt_rd_addr;
    page_entry_t            pt_rd_q;
    logic                   pv_q;
    page_entry_t            pt_entry;
    logic                   pt_wr_en;
    logic [PAGE_W-1:0]      pt_wr_addr;
    page_entry_t            pt_wr_data;

    // frame owner memory and valid bits
    logic [PAGE_W-1:0]      ow_mem [FRAMES];
    logic [FRAMES-1:0]      owner_valid_reg;
    logic                   ow_rd_en;
    logic [FRAME_W-1:0]     ow_rd_addr;
    logic [PAGE_W-1:0]      ow_rd_q;
    logic                   ow_wr_en;

    // sequencer
    fsm_t                   state_reg;
    logic [PAGE_W-1:0]      pg_reg;
    page_entry_t            cur_reg;
    logic [GROUP_W-1:0]     grp_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic [PAGE_W-1:0]      vp_reg;
    logic                   ev_valid_reg;
    logic                   ev_wb_reg;
    status_t                status_reg;

    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic [FRAME_W-1:0]     m_frame_reg;
    logic                   m_ev_valid_reg;
    logic [PAGE_W-1:0]      m_ev_page_reg;
    logic                   m_ev_wb_reg;
    logic [1:0]             m_prot_reg;

    // scan and modulo
    logic                   scan_hit;
    logic [LANE_W-1:0]      scan_lane;
    logic                   scan_last;
    logic [FRAME_CNT_W-1:0] next_base;
    logic                   urem_start;
    logic                   urem_done;
    logic [FRAME_W-1:0]     urem_rem;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    always_comb begin
        lfsr_step = {1'b0, lfsr_reg[SEED_W-1:1]};
        if (lfsr_reg[0]) begin
            lfsr_step = lfsr_step ^ LFSR_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_reg  <= PAGE_CNT_W'(PAGES);
            frames_reg <= FRAME_CNT_W'(FRAMES);
            lfsr_reg   <= SEED_W'(1);
        end else begin
            if (cfg_wr_en && cfg_wr_index == CFG_PAGES) begin
                pages_reg <= cfg_wr_data[PAGE_CNT_W-1:0];
            end
            if (cfg_wr_en && cfg_wr_index == CFG_FRAMES) begin
                frames_reg <= cfg_wr_data[FRAME_CNT_W-1:0];
            end
            if (cfg_wr_en && cfg_wr_index == CFG_SEED) begin
                // a zero seed would lock the LFSR
                lfsr_reg <= (cfg_wr_data[SEED_W-1:0] == '0) ? SEED_W'(1)
                                                            : cfg_wr_data[SEED_W-1:0];
            end else if (lfsr_adv) begin
                lfsr_reg <= lfsr_step;
            end
        end
    end

    always_comb begin
        np_eff   = (pages_reg > PAGE_CNT_W'(PAGES)) ? PAGE_CNT_W'(PAGES) : pages_reg;
        nf_eff   = (frames_reg > FRAME_CNT_W'(FRAMES)) ? FRAME_CNT_W'(FRAMES) : frames_reg;
        cfg_bad  = (np_eff == '0) || (nf_eff == '0) ||
                   (PAGE_CNT_W'(nf_eff) > np_eff);
        page_err = cfg_bad || (PAGE_CNT_W'(s_page_index) >= np_eff);
    end

    // ------------------------------------------------------------------------
    // page table: read, modify, write back
    // ------------------------------------------------------------------------
    always_comb begin
        pt_entry = pt_rd_q;
        if (!pv_q) begin
            pt_entry.state = PG_NOT_ALLOC;
            pt_entry.prior = PG_NOT_ALLOC;
            pt_entry.dirty = 1'b0;
            pt_entry.prot  = PERM_NONE;
        end
    end

    always_comb begin
        pt_rd_en   = (state_reg == S_IDLE && s_valid) || state_reg == S_RD_OWNER;
        pt_rd_addr = (state_reg == S_IDLE) ? s_page_index : ow_rd_q;

        pt_wr_en   = 1'b0;
        pt_wr_addr = pg_reg;
        pt_wr_data = pt_entry;
        case (state_reg)
            S_RD_PAGE: begin
                if (pt_entry.state == PG_IN_RAM) begin
                    pt_wr_en         = 1'b1;
                    pt_wr_data.dirty = 1'b1;
                    pt_wr_data.prot  = PERM_WRITE;
                end
            end
            S_RD_VICTIM: begin
                // move victim to swap, keep its frame field
                pt_wr_en         = 1'b1;
                pt_wr_addr       = vp_reg;
                pt_wr_data.state = PG_IN_SWAP;
                pt_wr_data.prior = pt_entry.state;
                pt_wr_data.dirty = 1'b0;
                pt_wr_data.prot  = PERM_NONE;
            end
            S_MAP: begin
                pt_wr_en         = 1'b1;
                pt_wr_data.state = PG_IN_RAM;
                pt_wr_data.prior = cur_reg.state;
                pt_wr_data.dirty = cur_reg.dirty;
                pt_wr_data.prot  = PERM_READ;
                pt_wr_data.frame = frame_reg;
            end
            default: begin
                pt_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pt_wr_en) begin
            pt_mem[pt_wr_addr] <= pt_wr_data;
        end
        if (pt_rd_en) begin
            pt_rd_q <= pt_mem[pt_rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // frame owner table
    // ------------------------------------------------------------------------
    assign ow_rd_en   = (state_reg == S_MOD) && urem_done;
    assign ow_rd_addr = urem_rem;
    assign ow_wr_en   = (state_reg == S_MAP);

    always_ff @(posedge aclk) begin
        if (ow_wr_en) begin
            ow_mem[frame_reg] <= pg_reg;
        end
        if (ow_rd_en) begin
            ow_rd_q <= ow_mem[ow_rd_addr];
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_valid_reg  <= '0;
            owner_valid_reg <= '0;
            pv_q            <= 1'b0;
        end else begin
            if (pt_rd_en) begin
                pv_q <= page_valid_reg[pt_rd_addr];
            end
            if (pt_wr_en) begin
                page_valid_reg[pt_wr_addr] <= 1'b1;
            end
            if (ow_wr_en) begin
                owner_valid_reg[frame_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // free-frame scan, one group of lanes per cycle
    // ------------------------------------------------------------------------
    always_comb begin
        logic [FRAME_W-1:0] f;
        scan_hit  = 1'b0;
        scan_lane = '0;
        for (int j = SCAN_LANES - 1; j >= 0; j--) begin
            f = {grp_reg, LANE_W'(j)};
            if (FRAME_CNT_W'(f) < nf_eff && !owner_valid_reg[f]) begin
                scan_hit  = 1'b1;
                scan_lane = LANE_W'(j);
            end
        end
        next_base = {1'b0, grp_reg, {LANE_W{1'b0}}} + FRAME_CNT_W'(SCAN_LANES);
        scan_last = (grp_reg == GROUP_W'(SCAN_GROUPS - 1)) || (next_base >= nf_eff);
    end

    assign urem_start = (state_reg == S_SCAN) && !scan_hit && scan_last;
    assign lfsr_adv   = urem_start;

    dpfe_urem u_urem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (urem_start),
        .dividend  (lfsr_step),
        .divisor   (nf_eff),
        .done      (urem_done),
        .remainder (urem_rem)
    );

    // ------------------------------------------------------------------------
    // sequencer and result register
    // ------------------------------------------------------------------------
    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pg_reg         <= '0;
            cur_reg        <= '0;
            grp_reg        <= '0;
            frame_reg      <= '0;
            vp_reg         <= '0;
            ev_valid_reg   <= 1'b0;
            ev_wb_reg      <= 1'b0;
            status_reg     <= ST_ERROR;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= '0;
            m_frame_reg    <= '0;
            m_ev_valid_reg <= 1'b0;
            m_ev_page_reg  <= '0;
            m_ev_wb_reg    <= 1'b0;
            m_prot_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        pg_reg       <= s_page_index;
                        frame_reg    <= '0;
                        vp_reg       <= '0;
                        ev_valid_reg <= 1'b0;
                        ev_wb_reg    <= 1'b0;
                        if (page_err) begin
                            status_reg <= ST_ERROR;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_RD_PAGE;
                        end
                    end
                end
                S_RD_PAGE: begin
                    cur_reg <= pt_entry;
                    if (pt_entry.state == PG_IN_RAM) begin
                        status_reg <= ST_UPGRADE;
                        frame_reg  <= pt_entry.frame;
                        state_reg  <= S_OUT;
                    end else begin
                        grp_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        frame_reg <= {grp_reg, scan_lane};
                        state_reg <= S_MAP;
                    end else if (scan_last) begin
                        state_reg <= S_MOD;
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                S_MOD: begin
                    if (urem_done) begin
                        frame_reg <= urem_rem;
                        state_reg <= S_RD_OWNER;
                    end
                end
                S_RD_OWNER: begin
                    vp_reg    <= ow_rd_q;
                    state_reg <= S_RD_VICTIM;
                end
                S_RD_VICTIM: begin
                    ev_valid_reg <= 1'b1;
                    ev_wb_reg    <= pt_entry.dirty || (pt_entry.prior == PG_NOT_ALLOC);
                    state_reg    <= S_MAP;
                end
                S_MAP: begin
                    status_reg <= (cur_reg.state == PG_NOT_ALLOC) ? ST_ZERO_FILL
                                                                  : ST_SWAP_IN;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= status_reg;
                        m_frame_reg    <= frame_reg;
                        m_ev_valid_reg <= ev_valid_reg;
                        m_ev_page_reg  <= vp_reg;
                        m_ev_wb_reg    <= ev_wb_reg;
                        case (status_reg)
                            ST_UPGRADE:   m_prot_reg <= PERM_WRITE;
                            ST_ZERO_FILL: m_prot_reg <= PERM_READ;
                            ST_SWAP_IN:   m_prot_reg <= PERM_READ;
                            default:      m_prot_reg <= PERM_NONE;
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_frame_number    = m_frame_reg;
    assign m_evicted_valid   = m_ev_valid_reg;
    assign m_evicted_page    = m_ev_page_reg;
    assign m_evict_writeback = m_ev_wb_reg;
    assign m_new_protection  = m_prot_reg;

`ifndef NO_ASSERTIONS
    // one fault in flight: no second transfer right behind the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a fault is in flight");

    // a frame taken by the free-frame scan must be free at that point
    a_map_free_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAP && !ev_valid_reg |-> !owner_valid_reg[frame_reg])
        else $error("mapping into an owned frame");

    // the modulo unit finishes only while the sequencer waits for it
    a_urem_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        urem_done |-> state_reg == S_MOD)
        else $error("remainder done outside of victim selection");

    // an error result carries no frame, eviction or protection
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ERROR |->
            m_frame_number == '0 && !m_evicted_valid && !m_evict_writeback &&
            m_evicted_page == '0 && m_new_protection == PERM_NONE)
        else $error("error result with nonzero fields");
`endif

endmodule
